>>> hw/rtl/pid_control_step_top_macros.svh
// assertion helpers for the pid step block
`ifndef PID_CONTROL_STEP_TOP_MACROS_SVH
`define PID_CONTROL_STEP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PIDC_AST_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidc check failed");

// next-cycle implication, checked outside reset
`define PIDC_AST_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidc check failed");

`endif

>>> hw/rtl/pidc_pkg.sv
package pidc_pkg;

    localparam int DW  = 32;          // data word
    localparam int QW  = 16;          // fraction bits
    localparam int MW  = DW + 2;      // multiplier operand
    localparam int PW  = 2 * MW;      // product
    localparam int SW  = PW - QW;     // shifted product / sum width
    localparam int DVW = DW + 1 + QW; // dividend and quotient
    localparam int CIW = 3;           // register index

    localparam logic signed [DW-1:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [DW-1:0] S32_MIN = 32'sh80000000;

    localparam logic [CIW-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CIW-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CIW-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [CIW-1:0] REG_PERIOD      = 3'd3;
    localparam logic [CIW-1:0] REG_INT_LIMIT   = 3'd4;
    localparam logic [CIW-1:0] REG_OUT_FLOOR   = 3'd5;
    localparam logic [CIW-1:0] REG_OUT_CEILING = 3'd6;
    localparam logic [CIW-1:0] REG_ALPHA       = 3'd7;

    localparam logic [DW-1:0] RST_PERIOD    = 32'h0001_0000;
    localparam logic [DW-2:0] RST_INT_LIMIT = 31'h7fff_ffff;

    typedef enum logic [1:0] {
        OP_ERROR    = 2'd0,
        OP_SETPOINT = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_FILT, S_FILT_W, S_IGAIN, S_IGAIN_W, S_IPER, S_IPER_W,
        S_PGAIN, S_PGAIN_W, S_DGAIN, S_DGAIN_W, S_SUM
    } t_state;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [DW-1:0] err_in;
        logic signed [DW-1:0] target;
        logic signed [DW-1:0] measured;
        logic [DW-1:0]        step_time;
    } t_pidc_in;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic                 limited;
    } t_pidc_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [DW-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SW'(S32_MAX)) r = S32_MAX;
        else if (v < SW'(S32_MIN)) r = S32_MIN;
        else r = v[DW-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/pid_control_step_top.sv
// pid controller step, signed q16.16
// input channel i_valid/o_ready carries one item: op, error, setpoint,
// measurement and step time; output channel o_valid/i_ready carries the
// clamped drive and the limited flag, one result item per input item
// config: i_cfg_we writes i_cfg_data to register i_cfg_idx at once; the user
// must write only while the block is idle, the block itself does not enforce it
// op 0 and 1 run a sequencer over one shared 34x34 multiplier and one
// bit-serial divider: first the derivative divide, then up to five
// multiply steps, each a multiplier state and a wait state; the divider
// takes most of the time of an item
// op 2 (clear) and op 3 go straight to the final step with a zero drive
// o_ready is high only in the idle state; a finished result sits in the
// output register, so the next item is taken while it waits; a second
// result stalls in the final step until the receiver takes the first
// reset (synchronous, active low) loads the register defaults and
// zeroes the integrator, the last error and the last derivative
`include "pid_control_step_top_macros.svh"

module pid_control_step_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  pidc_pkg::t_pidc_in             i_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output pidc_pkg::t_pidc_out            o_out,
    input  logic                           i_cfg_we,
    input  logic [pidc_pkg::CIW-1:0]       i_cfg_idx,
    input  logic [pidc_pkg::DW-1:0]        i_cfg_data
);
    import pidc_pkg::*;

    // configuration registers
    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [DW-1:0]        r_period_cfg;
    logic [DW-2:0]        r_int_lim;
    logic signed [DW-1:0] r_floor, r_ceil;
    logic [QW:0]          r_alpha;

    // controller state
    logic signed [DW-1:0] r_integ, r_last_e, r_last_d;

    // per-item working registers
    t_state               r_state, n_state;
    logic [1:0]           r_op;
    logic signed [DW-1:0] r_e, r_d, r_t, r_p, r_dd;
    logic [DW-1:0]        r_period;
    logic                 r_out_valid;
    t_pidc_out            r_out;

    logic                 accept;
    logic signed [DW-1:0] in_e;
    logic [DW-1:0]        in_period;
    logic signed [DW:0]   in_diff;
    logic [DW:0]          diff_mag;
    logic                 div_start;
    t_div_stat            div_stat;
    logic [DVW-1:0]       div_quot;
    logic signed [DW-1:0] d_div;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_prod;
    logic signed [DW-1:0] prod_q;
    logic signed [DW-1:0] filt_d;
    logic signed [DW-1:0] integ_sum, integ_new;
    logic signed [DW-1:0] y_sum, y_lo, y_clamp;
    logic                 out_free;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // error and period for the incoming item
    always_comb begin
        if (i_in.op == OP_SETPOINT) begin
            in_e      = sat32(SW'(i_in.target) - SW'(i_in.measured));
            in_period = i_in.step_time;
        end else begin
            in_e      = i_in.err_in;
            in_period = r_period_cfg;
        end
        in_diff   = (DW+1)'(in_e) - (DW+1)'(r_last_e);
        diff_mag  = in_diff[DW] ? (DW+1)'(-in_diff) : in_diff;
        div_start = accept && (i_in.op == OP_ERROR || i_in.op == OP_SETPOINT)
                    && (in_period != '0);
    end

    pidc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({diff_mag, {QW{1'b0}}}),
        .i_divisor  (in_period),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // signed, saturated derivative from the magnitude quotient
    always_comb begin
        if (r_period == '0) begin
            d_div = '0;
        end else if (r_e < r_last_e) begin
            d_div = (div_quot > DVW'(33'h0_8000_0000)) ? S32_MIN
                    : DW'(-div_quot);
        end else begin
            d_div = (div_quot > DVW'(S32_MAX)) ? S32_MAX : div_quot[DW-1:0];
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_FILT: begin
                mul_a = MW'({1'b0, r_alpha});
                mul_b = MW'(r_d) - MW'(r_last_d);
            end
            S_IGAIN: begin
                mul_a = MW'(r_e);
                mul_b = MW'(r_gain_i);
            end
            S_IPER: begin
                mul_a = MW'(r_t);
                mul_b = MW'({1'b0, r_period});
            end
            S_PGAIN: begin
                mul_a = MW'(r_gain_p);
                mul_b = MW'(r_e);
            end
            S_DGAIN: begin
                mul_a = MW'(r_gain_d);
                mul_b = MW'(r_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pidc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // product back to q16.16, floor then saturate
    always_comb begin
        prod_q    = sat32(mul_prod[PW-1:QW]);
        filt_d    = sat32(SW'(r_last_d) + mul_prod[PW-1:QW]);
        integ_sum = sat32(SW'(r_integ) + SW'(prod_q));
        if (SW'(integ_sum) > $signed(SW'(r_int_lim))) integ_new = DW'(r_int_lim);
        else if (SW'(integ_sum) < -$signed(SW'(r_int_lim)))
            integ_new = DW'(-SW'(r_int_lim));
        else integ_new = integ_sum;
    end

    // output sum and clamp, floor of zero means minus the ceiling
    always_comb begin
        y_sum = sat32(SW'(r_p) + SW'(r_integ) + SW'(r_dd));
        if (r_floor != '0) y_lo = r_floor;
        else y_lo = sat32(-SW'(r_ceil));
        priority if (y_sum < y_lo) y_clamp = y_lo;
        else if (y_sum > r_ceil) y_clamp = r_ceil;
        else y_clamp = y_sum;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.op == OP_ERROR || i_in.op == OP_SETPOINT) n_state = S_DIV;
                    else n_state = S_SUM;
                end
            end
            S_DIV: begin
                if (r_period == '0 || div_stat.done) begin
                    if (r_op == OP_ERROR && r_alpha != '0) n_state = S_FILT;
                    else n_state = S_IGAIN;
                end
            end
            S_FILT:    n_state = S_FILT_W;
            S_FILT_W:  n_state = S_IGAIN;
            S_IGAIN:   n_state = S_IGAIN_W;
            S_IGAIN_W: n_state = S_IPER;
            S_IPER:    n_state = S_IPER_W;
            S_IPER_W:  n_state = S_PGAIN;
            S_PGAIN:   n_state = S_PGAIN_W;
            S_PGAIN_W: n_state = S_DGAIN;
            S_DGAIN:   n_state = S_DGAIN_W;
            S_DGAIN_W: n_state = S_SUM;
            S_SUM: begin
                if (out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = r_out_valid;
        o_out   = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_period_cfg <= RST_PERIOD;
            r_int_lim    <= RST_INT_LIMIT;
            r_floor      <= '0;
            r_ceil       <= S32_MAX;
            r_alpha      <= '0;
            r_integ      <= '0;
            r_last_e     <= '0;
            r_last_d     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GAIN_P:      r_gain_p     <= i_cfg_data;
                    REG_GAIN_I:      r_gain_i     <= i_cfg_data;
                    REG_GAIN_D:      r_gain_d     <= i_cfg_data;
                    REG_PERIOD:      r_period_cfg <= i_cfg_data;
                    REG_INT_LIMIT:   r_int_lim    <= i_cfg_data[DW-2:0];
                    REG_OUT_FLOOR:   r_floor      <= i_cfg_data;
                    REG_OUT_CEILING: r_ceil       <= i_cfg_data;
                    REG_ALPHA:       r_alpha      <= i_cfg_data[QW:0];
                    default:         r_alpha      <= r_alpha;
                endcase
            end

            // a new result takes the output register as the old one leaves
            if (r_state == S_SUM && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_in.op == OP_CLEAR) begin
                        r_integ  <= '0;
                        r_last_e <= '0;
                        r_last_d <= '0;
                    end
                end
                S_DIV: begin
                    // unfiltered derivative is stored for op 0 right away
                    if ((r_period == '0 || div_stat.done) && r_op == OP_ERROR
                        && r_alpha == '0) begin
                        r_last_d <= d_div;
                    end
                end
                S_FILT_W: r_last_d <= filt_d;
                S_IPER_W: begin
                    r_integ  <= integ_new;
                    r_last_e <= r_e;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in.op;
            r_e      <= in_e;
            r_period <= in_period;
        end
        unique case (r_state)
            S_DIV: begin
                if (r_period == '0 || div_stat.done) r_d <= d_div;
            end
            S_FILT_W:  r_d  <= filt_d;
            S_IGAIN_W: r_t  <= prod_q;
            S_PGAIN_W: r_p  <= prod_q;
            S_DGAIN_W: r_dd <= prod_q;
            S_SUM: begin
                if (out_free) begin
                    if (r_op == OP_ERROR || r_op == OP_SETPOINT) begin
                        r_out.drive   <= y_clamp;
                        r_out.limited <= (y_clamp != y_sum);
                    end else begin
                        r_out.drive   <= '0;
                        r_out.limited <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // clear item leaves zero state behind
    `PIDC_AST_NXT(a_clear_state, accept && i_in.op == OP_CLEAR, r_integ == '0 && r_last_e == '0 && r_last_d == '0)
    // divider only runs while the sequencer waits on it
    `PIDC_AST_IMP(a_div_owned, div_stat.busy || div_stat.done, r_state == S_DIV)
    // an accepted item always leaves idle
    `PIDC_AST_NXT(a_leave_idle, accept, r_state != S_IDLE)
    // integrator never exceeds the limit right after its update
    `PIDC_AST_NXT(a_integ_bound, r_state == S_IPER_W, SW'(r_integ) <= $signed(SW'(r_int_lim)) && SW'(r_integ) >= -$signed(SW'(r_int_lim)))

endmodule

>>> hw/rtl/pidc_mul.sv
module pidc_mul (
    input  logic                              i_clk,
    input  logic signed [pidc_pkg::MW-1:0]    i_a,
    input  logic signed [pidc_pkg::MW-1:0]    i_b,
    output logic signed [pidc_pkg::PW-1:0]    o_prod
);
    import pidc_pkg::*;

    logic signed [PW-1:0] r_prod;

    // one registered signed product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/pidc_div.sv
module pidc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pidc_pkg::DVW-1:0]     i_dividend,
    input  logic [pidc_pkg::DW-1:0]      i_divisor,
    output pidc_pkg::t_div_stat          o_stat,
    output logic [pidc_pkg::DVW-1:0]     o_quot
);
    import pidc_pkg::*;

    localparam int CW = $clog2(DVW);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DVW-1:0]  r_quo, n_quo;
    logic [DW-1:0]   r_div;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    // restoring divide, one quotient bit a cycle
    always_comb begin
        trial  = {r_rem, r_quo[DVW-1]};
        diff   = trial - {1'b0, r_div};
        ge     = trial >= {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DVW - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
            n_quo = {r_quo[DVW-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) r_div <= i_divisor;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pidc_pkg::*;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // block ports
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_pidc_in  i_in = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_pidc_out o_out;
    logic            i_cfg_we = 1'b0;
    logic [CIW-1:0]  i_cfg_idx = '0;
    logic [DW-1:0]   i_cfg_data = '0;

    pid_control_step_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor copy of the registers and the controller state
    logic signed [31:0] kp, ki, kd, floor_r, ceil_r;
    logic [31:0] period_r;
    logic [30:0] ilim_r;
    logic [16:0] alpha_r;
    logic signed [31:0] integ, prev_err, prev_deriv;

    t_pidc_in  pending_items[$];
    t_pidc_out expected_drive[$];

    int  mismatches = 0;
    int  cycle = 0;
    int  send_idle_pct = 0;  // chance in 100 that the driver stays idle
    int  recv_stall_pct = 0; // chance in 100 that the monitor stalls
    int  hold_cycles = 0;    // long receiver hold-off, counted down below

    function automatic logic signed [31:0] clip32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) return 32'sh7fffffff;
        if (v < -80'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // q16.16 product, floor shift, saturated
    function automatic logic signed [31:0] fxmul(input logic signed [32:0] a,
                                                  input logic signed [32:0] b);
        logic signed [79:0] p;
        p = 80'(a) * 80'(b);
        return clip32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] slope(input logic signed [31:0] e,
                                                  input logic [31:0] per);
        logic signed [79:0] diff;
        if (per == 0) return 0;
        diff = (80'(e) - 80'(prev_err)) * 80'sd65536;
        return clip32(diff / $signed({48'd0, per}));
    endfunction

    // one pid step on the predictor state
    function automatic t_pidc_out pid_predict(input t_pidc_in it);
        t_pidc_out r;
        logic signed [31:0] e, d, inc, v, lo, y;
        logic signed [79:0] delta;
        logic [31:0] per;
        r = '0;
        if (it.op == OP_CLEAR) begin
            integ = 0; prev_err = 0; prev_deriv = 0;
            return r;
        end
        if (it.op == OP_UNUSED) return r;
        if (it.op == OP_ERROR) begin
            e = it.err_in;
            per = period_r;
            d = slope(e, per);
            if (alpha_r != 0) begin
                delta = 80'(d) - 80'(prev_deriv);
                d = clip32(80'(prev_deriv) + ((80'($signed({1'b0, alpha_r})) * delta) >>> 16));
            end
            prev_deriv = d;
        end else begin
            e = clip32(80'(it.target) - 80'(it.measured));
            per = it.step_time;
            d = slope(e, per);
        end
        inc = fxmul(fxmul(e, ki), $signed({1'b0, per}));
        v = clip32(80'(integ) + 80'(inc));
        if (80'(v) > 80'($signed({1'b0, ilim_r}))) v = {1'b0, ilim_r};
        if (80'(v) < -80'($signed({1'b0, ilim_r}))) v = -$signed({1'b0, ilim_r});
        integ = v;
        prev_err = e;
        y = clip32(80'(fxmul(kp, e)) + 80'(integ) + 80'(fxmul(kd, d)));
        lo = (floor_r != 0) ? floor_r : clip32(-80'(ceil_r));
        r.drive = y;
        if (y < lo) r.drive = lo;
        else if (y > ceil_r) r.drive = ceil_r;
        r.limited = (r.drive != y);
        return r;
    endfunction

    // driver: offers the next pending item, holds it until accepted
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            expected_drive.push_back(pid_predict(i_in));
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in <= pending_items.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid && i_rst_n && pending_items.size() > 0
                     && $urandom_range(99) >= send_idle_pct) begin
            i_in <= pending_items.pop_front();
            i_valid <= 1'b1;
        end
    end

    // monitor: compares each result item against the oldest expectation
    always @(posedge i_clk) begin
        t_pidc_out want;
        cycle <= cycle + 1;
        if (o_valid && i_ready) begin
            if (expected_drive.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("result item with nothing expected: %h", o_out);
            end else begin
                want = expected_drive.pop_front();
                if (want.drive !== o_out.drive || want.limited !== o_out.limited) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: drive exp %0d got %0d, limited exp %0b got %0b",
                                 want.drive, o_out.drive, want.limited, o_out.limited);
                end
            end
        end
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // receiver hold-off countdown
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (cycle > 1500000) begin
            $display("[pid_control_step_top] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_GAIN_P:      kp = val;
            REG_GAIN_I:      ki = val;
            REG_GAIN_D:      kd = val;
            REG_PERIOD:      period_r = val;
            REG_INT_LIMIT:   ilim_r = val[30:0];
            REG_OUT_FLOOR:   floor_r = val;
            REG_OUT_CEILING: ceil_r = val;
            default:         alpha_r = val[16:0];
        endcase
    endtask

    // wait for the block to drain before reconfiguring
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_drive.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            3: return $urandom_range(0, 32'hfffff) - 32'h7ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pidc_in rand_item();
        t_pidc_in it;
        it.err_in = pick32();
        it.target = pick32();
        it.measured = pick32();
        it.step_time = ($urandom_range(9) == 0) ? pick32() : $urandom_range(0, 32'h3ffff);
        case ($urandom_range(19))
            0:       it.op = OP_CLEAR;
            1:       it.op = OP_UNUSED;
            2,3,4,5,6,7,8,9: it.op = OP_SETPOINT;
            default: it.op = OP_ERROR;
        endcase
        return it;
    endfunction

    function automatic logic [31:0] gain_pick();
        case ($urandom_range(4))
            0:       return pick32();
            default: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
        endcase
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        drain();
        write_reg(REG_GAIN_P, gain_pick());
        write_reg(REG_GAIN_I, gain_pick());
        write_reg(REG_GAIN_D, gain_pick());
        write_reg(REG_PERIOD, ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(1, 32'h2ffff));
        write_reg(REG_INT_LIMIT, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'hfffff));
        write_reg(REG_OUT_FLOOR, ($urandom_range(2) == 0) ? 32'd0 : pick32());
        write_reg(REG_OUT_CEILING, pick32());
        write_reg(REG_ALPHA, ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(0, 32'h1ffff));
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) pending_items.push_back(rand_item());
    endtask

    initial begin
        t_pidc_in it;
        logic [31:0] edges[4];
        edges = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
        kp = 0; ki = 0; kd = 0; period_r = RST_PERIOD; ilim_r = RST_INT_LIMIT;
        floor_r = 0; ceil_r = 32'sh7fffffff; alpha_r = 0;
        integ = 0; prev_err = 0; prev_deriv = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme fields, every op, zero period, overflow, alpha above one
        write_reg(REG_GAIN_P, 32'h0001_0000);
        write_reg(REG_GAIN_I, 32'h7fffffff);
        write_reg(REG_GAIN_D, 32'h80000000);
        write_reg(REG_ALPHA, 32'h0001_ffff);
        for (int k = 0; k < 4; k++) begin
            it = '0; it.op = OP_ERROR; it.err_in = edges[k];
            pending_items.push_back(it);
            it.op = OP_SETPOINT; it.target = edges[k]; it.measured = edges[3 - k];
            it.step_time = edges[k];
            pending_items.push_back(it);
        end
        it = '0; it.op = OP_CLEAR; pending_items.push_back(it);
        it.op = OP_UNUSED; it.err_in = 32'hffffffff; pending_items.push_back(it);
        it.op = OP_SETPOINT; it.step_time = 0; it.target = 32'h00050000;
        pending_items.push_back(it);
        drain();
        // crossed bounds and floor negation of the most negative ceiling
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_OUT_FLOOR, 32'h0010_0000);
        write_reg(REG_OUT_CEILING, 32'hfff0_0000);
        write_reg(REG_INT_LIMIT, 32'h0);
        for (int k = 0; k < 4; k++) begin
            it = '0; it.op = OP_ERROR; it.err_in = edges[k]; pending_items.push_back(it);
        end
        drain();
        write_reg(REG_OUT_FLOOR, 32'h0);
        write_reg(REG_OUT_CEILING, 32'h80000000);
        write_reg(REG_ALPHA, 32'h0001_0000);
        it = '0; it.op = OP_ERROR; it.err_in = 32'h00020000; pending_items.push_back(it);
        it.err_in = 32'h80000000; pending_items.push_back(it);

        // random phases with different idle patterns
        random_phase(400, 0, 0);
        random_phase(300, 73, 0);
        random_phase(300, 0, 73);
        random_phase(300, 7, 7);
        // receiver holds off while the sender keeps offering
        random_phase(150, 0, 0);
        hold_cycles = 2000;
        // sender pauses until every result is in, then resumes
        random_phase(200, 30, 30);
        drain();
        if (mismatches == 0) begin
            $display("[pid_control_step_top] OK");
        end else begin
            $display("[pid_control_step_top] ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_mul.sv
hw/rtl/pidc_div.sv
hw/rtl/pid_control_step_top.sv
tb/sv/testbench.sv
